/* rtl/sadc_pkg.sv */
// Shared constants, types and request codes for the serial converter channel model.
// No dependencies; imported by sadc_chan_bank and serial_adc_channel_model.
`timescale 1ns / 1ps
`default_nettype none

package sadc_pkg;

  localparam int unsigned CHANNELS    = 8;
  localparam int unsigned SAMPLE_BITS = 10;

  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned SEL_W  = 3;
  localparam int unsigned CMD_W  = 16;
  localparam int unsigned REQ_W  = 2;

  localparam logic [SAMPLE_BITS-1:0] VALUE_MAX  = {SAMPLE_BITS{1'b1}};
  localparam logic [POS_W-1:0]       POS_FULL   = POS_W'(SAMPLE_BITS);
  localparam int unsigned            RESET_STEP = 128;

  localparam logic [CMD_W-1:0] CMD_RELOAD = 16'h4040;
  localparam logic [CMD_W-1:0] CMD_SEL_LO = 16'h6040;
  localparam logic [CMD_W-1:0] CMD_SEL_HI = 16'h6740;

  typedef enum logic [REQ_W-1:0] {
    REQ_CMD  = 2'd0,
    REQ_READ = 2'd1,
    REQ_INC  = 2'd2,
    REQ_DEC  = 2'd3
  } req_e;

  // State update request from the decoder to the channel bank.
  typedef struct packed {
    logic             pos_we;
    logic [CH_W-1:0]  pos_idx;
    logic [POS_W-1:0] pos_val;
    logic             adj_en;
    logic [CH_W-1:0]  adj_idx;
    logic             adj_up;
  } sadc_op_t;

endpackage

`default_nettype wire

/* rtl/sadc_chan_bank.sv */
// Per-channel sample values and bit positions with saturating adjust.
// Depends on sadc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sadc_chan_bank (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sadc_pkg::sadc_op_t            op_i,
  input  wire logic [sadc_pkg::CH_W-1:0]     rd_idx_i,
  output logic [sadc_pkg::SAMPLE_BITS-1:0]   rd_value_o,
  output logic [sadc_pkg::POS_W-1:0]         rd_pos_o
);
  import sadc_pkg::*;

  logic [SAMPLE_BITS-1:0] value_q [CHANNELS];
  logic [SAMPLE_BITS-1:0] value_d [CHANNELS];
  logic [POS_W-1:0]       pos_q   [CHANNELS];
  logic [POS_W-1:0]       pos_d   [CHANNELS];

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      value_d[i] = value_q[i];
      pos_d[i]   = pos_q[i];
      if (op_i.pos_we && (op_i.pos_idx == CH_W'(i))) begin
        pos_d[i] = op_i.pos_val;
      end
      if (op_i.adj_en && (op_i.adj_idx == CH_W'(i))) begin
        if (op_i.adj_up) begin
          if (value_q[i] != VALUE_MAX) value_d[i] = value_q[i] + 1'b1;
        end else begin
          if (value_q[i] != '0) value_d[i] = value_q[i] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        value_q[i] <= SAMPLE_BITS'(i * RESET_STEP);
        pos_q[i]   <= '0;
      end
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        value_q[i] <= value_d[i];
        pos_q[i]   <= pos_d[i];
      end
    end
  end

  assign rd_value_o = value_q[rd_idx_i];
  assign rd_pos_o   = pos_q[rd_idx_i];

endmodule

`default_nettype wire

/* rtl/serial_adc_channel_model.sv */
// Top level of the serial converter channel model: request decode, result register.
// Depends on sadc_pkg and sadc_chan_bank.
// A result appears on the master side in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle unless the result side stalls; all state updates finish in the accepting cycle.
// The single result register empties and refills in the same cycle when downstream takes it.
// Reset (rst_ni low, asynchronous): channel n holds n*128 (truncated), all positions 0,
// channel 0 selected, data line low, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module serial_adc_channel_model (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // [15:0] command_word, [18:16] channel, rest 0
  input  wire logic [1:0]  s_axis_tuser_i,  // [1:0] req_type
  // Result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o   // [0] data_bit, [1] position_error, rest 0
);
  import sadc_pkg::*;

  // Unpacked request fields
  req_e             req;
  logic [CMD_W-1:0] cmd;
  logic [SEL_W-1:0] adj_ch;

  assign req    = req_e'(s_axis_tuser_i);
  assign cmd    = s_axis_tdata_i[15:0];
  assign adj_ch = s_axis_tdata_i[18:16];

  // Handshake: take a new transaction whenever the result slot is free or draining.
  logic out_valid_q;
  logic accept;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Architectural state held here: selected channel and data line level.
  logic [SEL_W-1:0] sel_q, sel_d;
  logic             data_out_q, data_out_d;
  logic             err_d;

  // Bank read port follows the selected channel.
  logic [SAMPLE_BITS-1:0] sel_value;
  logic [POS_W-1:0]       sel_pos;
  logic [POS_W-1:0]       pos_m1;
  logic [SAMPLE_BITS-1:0] shifted;
  sadc_op_t               op;

  assign pos_m1  = sel_pos - 1'b1;
  assign shifted = sel_value >> pos_m1;

  // Select command decode: window check, then channel number from bits [10:8] of the offset.
  logic [CMD_W-1:0] sel_off;
  logic [SEL_W-1:0] sel_cmd_ch;
  logic             sel_hit;

  assign sel_off    = cmd - CMD_SEL_LO;
  assign sel_cmd_ch = sel_off[10:8];
  assign sel_hit    = (cmd >= CMD_SEL_LO) && (cmd <= CMD_SEL_HI)
                      && (32'(sel_cmd_ch) < CHANNELS);

  always_comb begin
    op         = '0;
    sel_d      = sel_q;
    data_out_d = data_out_q;
    err_d      = 1'b0;
    if (accept) begin
      unique case (req)
        REQ_CMD: begin
          if (cmd == CMD_RELOAD) begin
            // Re-arm the current channel
            op.pos_we  = 1'b1;
            op.pos_idx = sel_q[CH_W-1:0];
            op.pos_val = POS_FULL;
          end else if (sel_hit) begin
            sel_d      = sel_cmd_ch;
            op.pos_we  = 1'b1;
            op.pos_idx = sel_cmd_ch[CH_W-1:0];
            op.pos_val = POS_FULL;
          end
        end
        REQ_READ: begin
          if (sel_pos == '0) begin
            // Ran out of bits: line low, flag the error
            data_out_d = 1'b0;
            err_d      = 1'b1;
          end else begin
            op.pos_we  = 1'b1;
            op.pos_idx = sel_q[CH_W-1:0];
            op.pos_val = pos_m1;
            data_out_d = shifted[0];
          end
        end
        REQ_INC, REQ_DEC: begin
          if (32'(adj_ch) < CHANNELS) begin
            op.adj_en  = 1'b1;
            op.adj_idx = adj_ch[CH_W-1:0];
            op.adj_up  = (req == REQ_INC);
          end
        end
        default: ;
      endcase
    end
  end

  sadc_chan_bank u_bank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .rd_idx_i   (sel_q[CH_W-1:0]),
    .rd_value_o (sel_value),
    .rd_pos_o   (sel_pos)
  );

  // Result register
  logic out_bit_q, out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= '0;
      data_out_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sel_q      <= sel_d;
      data_out_q <= data_out_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_bit_q <= data_out_d;
      out_err_q <= err_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_err_q, out_bit_q};

  // Checks
  a_err_forces_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_err_q |-> !out_bit_q)
    else $error("position error with data line high");

  a_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q && (out_bit_q == data_out_q))
    else $error("result missing or not matching data line");

  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sel_pos) <= SAMPLE_BITS)
    else $error("bit position beyond sample width");

  a_sel_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sel_q) < CHANNELS)
    else $error("selected channel out of range");

  a_idle_holds_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(data_out_q) && $stable(sel_q))
    else $error("state changed without a transaction");

endmodule

`default_nettype wire

/* sim/serial_adc_channel_model_tb.sv */
// Self-checking testbench for serial_adc_channel_model: a queue-fed stream driver,
// a result monitor and a bit-exact channel predictor. Depends on sadc_pkg and the RTL.
`timescale 1ns / 1ps

module serial_adc_channel_model_tb;
  import sadc_pkg::*;

  // Generous cycle limit: at most ~2.1k transactions, each with worst-case sender gap and
  // receiver stall, stays far below this.
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned DRAIN_EVERY  = 600;   // sender waits for an empty scoreboard
  localparam int unsigned TAIL_CYCLES  = 8;     // result is registered; plenty of margin

  // One request transaction as the sender queues it.
  typedef struct {
    req_e        kind;
    logic [15:0] cmd;
    logic [2:0]  ch;
    bit          drain;  // hold this transaction until every result is back
  } adc_req_t;

  // One expected result transaction.
  typedef struct {
    bit data_bit;
    bit pos_err;
  } adc_bit_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  serial_adc_channel_model i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [15:0] command_word, [18:16] channel, rest 0
    .s_axis_tuser_i  (s_tuser),   // [1:0] req_type
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)    // [0] data_bit, [1] position_error, rest 0
  );

  // Pending requests (filled by the stimulus block) and outstanding expected bits.
  adc_req_t    pend_q[$];
  adc_bit_t    bit_q[$];

  // Predictor state: a private copy of the converter's channels.
  logic [SAMPLE_BITS-1:0] chan_val[CHANNELS];
  logic [POS_W-1:0]       bit_pos[CHANNELS];
  logic [SEL_W-1:0]       sel_ch;
  bit                     line_lvl;

  // Coverage-ish counters for the closing summary.
  int unsigned n_in, n_out, n_reads, n_empty_reads, n_selects, n_reloads;
  int unsigned n_sat_hi, n_sat_lo, n_drains;
  int unsigned err_cnt;
  int unsigned cycle_cnt;

  // Handshake bookkeeping between posedge monitor and negedge driver.
  bit          in_fire;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          tx_quiet, rx_quiet;   // stretches with no idling at all
  adc_req_t    cur;
  adc_bit_t    want;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  task automatic reset_channels();
    for (int i = 0; i < CHANNELS; i++) begin
      chan_val[i] = SAMPLE_BITS'(i * RESET_STEP);
      bit_pos[i]  = '0;
    end
    sel_ch   = '0;
    line_lvl = 1'b0;
  endtask

  // Applies one accepted request to the channel copy and returns the line state.
  function automatic adc_bit_t shift_out_bit(req_e kind, logic [15:0] cmd, logic [2:0] ch);
    adc_bit_t         res;
    logic [SEL_W-1:0] tgt;
    int unsigned      rd;
    res.pos_err = 1'b0;
    case (kind)
      REQ_CMD: begin
        if (cmd == CMD_RELOAD) begin
          if (int'(sel_ch) < CHANNELS) bit_pos[sel_ch] = POS_FULL;
          n_reloads++;
        end else if (cmd >= CMD_SEL_LO && cmd <= CMD_SEL_HI) begin
          tgt = SEL_W'((cmd - CMD_SEL_LO) >> 8);
          if (int'(tgt) < CHANNELS) begin
            sel_ch       = tgt;
            bit_pos[tgt] = POS_FULL;
            n_selects++;
          end
        end
        // anything else leaves the state alone
      end
      REQ_READ: begin
        rd = (int'(sel_ch) < CHANNELS) ? sel_ch : 0;
        n_reads++;
        if (bit_pos[rd] == '0) begin
          // no bits left: line forced low, flag raised
          line_lvl    = 1'b0;
          res.pos_err = 1'b1;
          n_empty_reads++;
        end else begin
          bit_pos[rd] = bit_pos[rd] - 1'b1;
          line_lvl    = chan_val[rd][bit_pos[rd]];
        end
      end
      REQ_INC: begin
        if (int'(ch) < CHANNELS) begin
          if (chan_val[ch] < VALUE_MAX) chan_val[ch] = chan_val[ch] + 1'b1;
          else n_sat_hi++;
        end
      end
      default: begin  // REQ_DEC
        if (int'(ch) < CHANNELS) begin
          if (chan_val[ch] > '0) chan_val[ch] = chan_val[ch] - 1'b1;
          else n_sat_lo++;
        end
      end
    endcase
    res.data_bit = line_lvl;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle / stall lengths: mostly none or short, now and then long.
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: request side changes on the falling edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_tvalid || in_fire) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pend_q.size() != 0 && !(pend_q[0].drain && bit_q.size() != 0)) begin
          cur = pend_q.pop_front();
          s_tdata  <= {5'b0, cur.ch, cur.cmd};
          s_tuser  <= cur.kind;
          s_tvalid <= 1'b1;
          gap_left <= pick_gap(tx_quiet);
          if ($urandom_range(0, 59) == 0) tx_quiet <= !tx_quiet;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure, also on the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_tready   <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!rx_quiet && $urandom_range(0, 3) == 0) stall_left <= pick_gap(1'b0);
        if ($urandom_range(0, 149) == 0) rx_quiet <= !rx_quiet;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled on the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    in_fire   <= rst_ni && s_tvalid && s_tready;
    if (rst_ni) begin
      // Result first: the item accepted this edge cannot have produced it yet.
      if (m_tvalid && m_tready) begin
        n_out++;
        if (bit_q.size() == 0) begin
          $error("result transaction with nothing expected: tdata=%h", m_tdata);
          err_cnt++;
        end else begin
          want = bit_q.pop_front();
          if (m_tdata[0] !== want.data_bit) begin
            $error("data_bit: expected %0d, got %0b", want.data_bit, m_tdata[0]);
            err_cnt++;
          end
          if (m_tdata[1] !== want.pos_err) begin
            $error("position_error: expected %0d, got %0b", want.pos_err, m_tdata[1]);
            err_cnt++;
          end
          if (m_tdata[7:2] !== 6'b0) begin
            $error("tdata padding: expected 0, got %h", m_tdata[7:2]);
            err_cnt++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        n_in++;
        bit_q.push_back(shift_out_bit(req_e'(s_tuser), s_tdata[15:0], s_tdata[18:16]));
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, bit_q.size());
      $display("serial_adc_channel_model_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  int unsigned n_queued;
  int unsigned next_drain;

  task automatic add_req(req_e kind, logic [15:0] cmd, logic [2:0] ch);
    adc_req_t it;
    it.kind  = kind;
    it.cmd   = cmd;
    it.ch    = ch;
    it.drain = 1'b0;
    // pressure point: sender stalls until the scoreboard is empty
    if (n_queued >= next_drain) begin
      it.drain = 1'b1;
      next_drain += DRAIN_EVERY;
      n_drains++;
    end
    pend_q.push_back(it);
    n_queued++;
  endtask

  // Unused fields carry random junk; the block must ignore them.
  task automatic add_read();
    add_req(REQ_READ, 16'($urandom), 3'($urandom));
  endtask

  task automatic add_cmd(logic [15:0] cmd);
    add_req(REQ_CMD, cmd, 3'($urandom));
  endtask

  task automatic add_adjust(bit up, logic [2:0] ch, int unsigned len);
    for (int unsigned k = 0; k < len; k++)
      add_req(up ? REQ_INC : REQ_DEC, 16'($urandom), ch);
  endtask

  initial begin
    int unsigned r, len;
    logic [2:0]  ch;
    logic [15:0] cmd;

    reset_channels();
    next_drain = 200;

    // Directed: read before any select (empty position on channel 0).
    add_read();
    // Reload on the default channel, drain all ten bits, then one too many.
    add_cmd(CMD_RELOAD);
    for (int i = 0; i < SAMPLE_BITS; i++) add_read();
    add_read();
    add_adjust(1'b0, 3'd0, 1);           // decrement sticks at zero
    add_cmd(CMD_SEL_HI);                 // top of select range: channel 7
    add_read();
    add_read();
    add_read();
    add_cmd(CMD_SEL_HI + 16'd1);         // just above the range: ignored
    add_cmd(CMD_SEL_LO - 16'd1);         // just below the range: ignored
    add_cmd(16'h0000);
    add_cmd(16'hFFFF);
    add_adjust(1'b1, 3'd7, 1);
    add_adjust(1'b0, 3'd3, 1);
    add_cmd(16'h60FF);                   // still channel 0
    add_cmd(16'h6540);                   // channel 5
    add_read();
    add_read();

    // Random part: mostly well-formed select/read sequences and adjust bursts,
    // plus boundary commands and free noise.
    while (n_queued < RANDOM_ITEMS + 26) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        ch  = 3'($urandom);
        cmd = CMD_SEL_LO + {5'b0, ch, 8'b0};
        if (ch != 3'd7) cmd = cmd + 16'($urandom_range(0, 255));
        add_cmd(cmd);
        len = $urandom_range(6, 12);
        for (int unsigned k = 0; k < len; k++) begin
          if ($urandom_range(0, 19) == 0) add_cmd(CMD_RELOAD);
          add_read();
        end
      end else if (r < 55) begin
        add_cmd(CMD_RELOAD);
        len = $urandom_range(1, 11);
        for (int unsigned k = 0; k < len; k++) add_read();
      end else if (r < 75) begin
        add_adjust(1'($urandom_range(0, 1)), 3'($urandom), $urandom_range(1, 20));
      end else if (r < 79) begin
        // long burst to reach the saturation limits
        if ($urandom_range(0, 3) != 0)
          add_adjust(1'b1, 3'($urandom_range(5, 7)), $urandom_range(130, 160));
        else
          add_adjust(1'b0, 3'($urandom_range(0, 2)), $urandom_range(130, 160));
      end else if (r < 88) begin
        case ($urandom_range(0, 5))
          0: add_cmd(CMD_SEL_LO - 16'd1);
          1: add_cmd(CMD_SEL_HI + 16'd1);
          2: add_cmd(CMD_RELOAD + 16'd1);
          3: add_cmd(CMD_RELOAD - 16'd1);
          4: add_cmd(16'h6000 + 16'($urandom_range(0, 16'h07FF)));
          default: add_cmd(CMD_SEL_HI);
        endcase
        add_read();
      end else begin
        len = $urandom_range(1, 6);
        for (int unsigned k = 0; k < len; k++)
          add_req(req_e'($urandom_range(0, 3)), 16'($urandom), 3'($urandom));
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for the sender to empty its queue, then for the scoreboard to drain.
    while (pend_q.size() != 0 || s_tvalid) @(posedge clk_i);
    while (bit_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    #1;

    if (bit_q.size() != 0) begin
      $error("%0d expected results never arrived", bit_q.size());
      err_cnt++;
    end
    $display("run: %0d requests, %0d results, %0d bit reads (%0d past the last bit)",
             n_in, n_out, n_reads, n_empty_reads);
    $display("     %0d selects, %0d reloads, %0d/%0d saturated inc/dec, %0d drain pauses",
             n_selects, n_reloads, n_sat_hi, n_sat_lo, n_drains);
    if (err_cnt == 0) begin
      $display("serial_adc_channel_model_tb OK");
    end else begin
      $display("serial_adc_channel_model_tb NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sadc_pkg.sv
rtl/sadc_chan_bank.sv
rtl/serial_adc_channel_model.sv
sim/serial_adc_channel_model_tb.sv
